### design/spectral_trend_motion_vote_assert.svh
// Assertion macros shared by the spectral trend motion voter RTL.
// Define NO_ASSERTIONS to compile the design without any checks.
`ifndef SPECTRAL_TREND_MOTION_VOTE_ASSERT_SVH
`define SPECTRAL_TREND_MOTION_VOTE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Antecedent implies consequent in the same cycle.
`define STMV_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Antecedent implies consequent in the following cycle.
`define STMV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define STMV_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define STMV_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

### design/stmv_pkg.sv
// Package for the spectral trend motion voter: widths, field offsets, codes
// and the command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package stmv_pkg;

   localparam int CHANNELS  = 4;
   localparam int FFT_SIZE  = 1024;
   localparam int BIN_BITS  = 24;

   localparam int CH_W      = 2;
   localparam int BIN_IDX_W = 10;
   localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam int SUM_W     = BIN_BITS + 11;
   localparam int SQ_W      = 2 * BIN_BITS;
   localparam int ROOT_W    = BIN_BITS;
   localparam int RCNT_W    = $clog2(ROOT_W + 1);
   localparam int PEAK_W    = 11;
   localparam int SEEN_W    = 2;
   localparam int TALLY_W   = 3;

   localparam logic [BIN_IDX_W-1:0] START_BIN_RESET = BIN_IDX_W'(3);
   localparam logic [BIN_IDX_W:0]   FFT_LIMIT       = (BIN_IDX_W + 1)'(FFT_SIZE);
   localparam logic [CH_W:0]        CH_LIMIT        = (CH_W + 1)'(CHANNELS);
   localparam logic [SUM_W-1:0]     SUM_MAX         = {SUM_W{1'b1}};
   localparam logic [TALLY_W-1:0]   TALLY_MAX       = {TALLY_W{1'b1}};
   localparam logic [PEAK_W-1:0]    PEAK_NONE       = {PEAK_W{1'b1}};
   localparam logic [SEEN_W-1:0]    SEEN_MAX        = SEEN_W'(3);
   localparam logic [SEEN_W-1:0]    SEEN_VOTE       = SEEN_W'(2);

   // Request tdata: bin_index, bin_real, bin_imag from bit 0 up.
   localparam int REQ_BIN_LSB  = 0;
   localparam int REQ_RE_LSB   = BIN_IDX_W;
   localparam int REQ_IM_LSB   = BIN_IDX_W + BIN_BITS;
   localparam int REQ_DATA_W   = ((BIN_IDX_W + 2 * BIN_BITS + 7) / 8) * 8;
   // Request tuser: channel, last_channel from bit 0 up.
   localparam int REQ_USER_W   = CH_W + 1;
   // Response tdata: verdict, approach_votes, depart_votes from bit 0 up.
   localparam int RSP_DATA_W   = 8;

   typedef enum logic [1:0] {
      TREND_NONE = 2'd0,
      TREND_RISE = 2'd1,
      TREND_FALL = 2'd2
   } trend_type;

   typedef enum logic [1:0] {
      VERDICT_UNKNOWN  = 2'd0,
      VERDICT_APPROACH = 2'd1,
      VERDICT_DEPART   = 2'd2
   } verdict_type;

   typedef struct packed {
      logic load_item;
      logic square;
      logic root_start;
      logic accum;
      logic vote;
      logic emit;
   } stmv_cmd_type;

   typedef struct packed {
      logic counted;
      logic last_bin;
      logic last_channel;
      logic root_busy;
      logic root_done;
   } stmv_status_type;

endpackage

### design/stmv_isqrt.sv
// Iterative integer square root, one root bit per cycle.
// Depends on stmv_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "spectral_trend_motion_vote_assert.svh"

module stmv_isqrt import stmv_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SQ_W-1:0]   radicand,
   output logic              busy,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   logic [SQ_W-1:0]   rad_ff;
   logic [ROOT_W+1:0] rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [RCNT_W-1:0] cnt_ff;
   logic              done_ff;

   logic [ROOT_W+1:0] rem_shift;
   logic [ROOT_W+1:0] trial;
   logic              take;

   // Bring down the next two radicand bits and try 4q+1 against the remainder.
   assign rem_shift = {rem_ff[ROOT_W-1:0], rad_ff[SQ_W-1 -: 2]};
   assign trial     = {root_ff, 2'b01};
   assign take      = (rem_shift >= trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else if (start) begin
         cnt_ff  <= RCNT_W'(ROOT_W);
         done_ff <= 1'b0;
      end else if (cnt_ff != '0) begin
         cnt_ff  <= cnt_ff - 1'b1;
         done_ff <= (cnt_ff == RCNT_W'(1));
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cnt_ff != '0) begin
         rad_ff  <= {rad_ff[SQ_W-3:0], 2'b00};
         if (take) begin
            rem_ff  <= rem_shift - trial;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_shift;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   assign busy = (cnt_ff != '0);
   assign done = done_ff;
   assign root = root_ff;

   // A finished root leaves a remainder no larger than twice the root.
   `STMV_ASSERT_IMPL(a_root_remainder, clock, reset, done_ff, {1'b0, rem_ff} <= {2'b00, root_ff, 1'b0}, "isqrt remainder out of range")
   // Completion is a single-cycle pulse.
   `STMV_ASSERT_NEXT(a_done_pulse, clock, reset, done_ff, !done_ff, "isqrt done held longer than one cycle")

endmodule

### design/stmv_datapath.sv
// Datapath of the spectral trend motion voter: request capture, squares,
// square root, frame sum and peak, per-channel history, vote tallies, result.
// Depends on stmv_pkg and stmv_isqrt.
`timescale 1ns / 1ps

module stmv_datapath import stmv_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [BIN_IDX_W-1:0]  csr_wr_data,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  logic                  req_tlast,
   input  stmv_cmd_type          cmd,
   output stmv_status_type       status,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [BIN_IDX_W-1:0] start_bin_ff;

   logic [BIN_IDX_W-1:0] bin_ff;
   logic [BIN_BITS-1:0]  re_ff;
   logic [BIN_BITS-1:0]  im_ff;
   logic [CH_W-1:0]      ch_ff;
   logic                 last_bin_ff;
   logic                 last_ch_ff;

   logic [SQ_W-1:0]      sq_re_ff;
   logic [SQ_W-1:0]      sq_im_ff;

   logic [SUM_W-1:0]     sum_ff;
   logic [ROOT_W-1:0]    peak_mag_ff;
   logic                 peak_found_ff;
   logic signed [PEAK_W-1:0] peak_bin_ff;

   logic [SUM_W-1:0]         pow_old_ff  [CHANNELS];
   logic [SUM_W-1:0]         pow_new_ff  [CHANNELS];
   logic signed [PEAK_W-1:0] peak_old_ff [CHANNELS];
   logic signed [PEAK_W-1:0] peak_new_ff [CHANNELS];
   logic [SEEN_W-1:0]        seen_ff     [CHANNELS];

   logic [TALLY_W-1:0]    appr_ff;
   logic [TALLY_W-1:0]    dep_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic [BIN_BITS-1:0] abs_re;
   logic [BIN_BITS-1:0] abs_im;
   logic                counted;
   logic                root_busy;
   logic                root_done;
   logic [ROOT_W-1:0]   root;
   logic [SUM_W:0]      sum_wide;
   logic [CH_IDX_W-1:0] ch_idx;
   logic                ch_ok;
   trend_type           pow_trend;
   trend_type           peak_trend;
   trend_type           vote;
   verdict_type         verdict;

   assign abs_re  = re_ff[BIN_BITS-1] ? (BIN_BITS'(0) - re_ff) : re_ff;
   assign abs_im  = im_ff[BIN_BITS-1] ? (BIN_BITS'(0) - im_ff) : im_ff;
   assign counted = (bin_ff >= start_bin_ff) && ({1'b0, bin_ff} < FFT_LIMIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         start_bin_ff <= START_BIN_RESET;
      end else if (csr_wr_en) begin
         start_bin_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         bin_ff      <= req_tdata[REQ_BIN_LSB +: BIN_IDX_W];
         re_ff       <= req_tdata[REQ_RE_LSB +: BIN_BITS];
         im_ff       <= req_tdata[REQ_IM_LSB +: BIN_BITS];
         ch_ff       <= req_tuser[CH_W-1:0];
         last_ch_ff  <= req_tuser[CH_W];
         last_bin_ff <= req_tlast;
      end
      if (cmd.square) begin
         sq_re_ff <= abs_re * abs_re;
         sq_im_ff <= abs_im * abs_im;
      end
   end

   stmv_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.root_start),
      .radicand (sq_re_ff + sq_im_ff),
      .busy     (root_busy),
      .done     (root_done),
      .root     (root)
   );

   assign sum_wide = {1'b0, sum_ff} + (SUM_W + 1)'(root);

   // Running frame: saturating magnitude sum and first bin of largest magnitude.
   always_ff @(posedge clock) begin
      if (reset || cmd.vote) begin
         sum_ff        <= '0;
         peak_mag_ff   <= '0;
         peak_found_ff <= 1'b0;
         peak_bin_ff   <= PEAK_NONE;
      end else if (cmd.accum) begin
         sum_ff <= sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
         if (!peak_found_ff || (root > peak_mag_ff)) begin
            peak_found_ff <= 1'b1;
            peak_mag_ff   <= root;
            peak_bin_ff   <= $signed({1'b0, bin_ff});
         end
      end
   end

   assign ch_idx = ch_ff[CH_IDX_W-1:0];
   assign ch_ok  = ({1'b0, ch_ff} < CH_LIMIT);

   always_comb begin
      if ((pow_old_ff[ch_idx] < pow_new_ff[ch_idx]) && (pow_new_ff[ch_idx] < sum_ff)) begin
         pow_trend = TREND_RISE;
      end else if ((pow_old_ff[ch_idx] > pow_new_ff[ch_idx]) &&
                   (pow_new_ff[ch_idx] > sum_ff)) begin
         pow_trend = TREND_FALL;
      end else begin
         pow_trend = TREND_NONE;
      end
      if ((peak_old_ff[ch_idx] < peak_new_ff[ch_idx]) &&
          (peak_new_ff[ch_idx] < peak_bin_ff)) begin
         peak_trend = TREND_RISE;
      end else if ((peak_old_ff[ch_idx] > peak_new_ff[ch_idx]) &&
                   (peak_new_ff[ch_idx] > peak_bin_ff)) begin
         peak_trend = TREND_FALL;
      end else begin
         peak_trend = TREND_NONE;
      end
      if (!ch_ok || (seen_ff[ch_idx] < SEEN_VOTE)) begin
         vote = TREND_NONE;
      end else if (pow_trend != TREND_NONE) begin
         vote = pow_trend;
      end else begin
         vote = peak_trend;
      end
   end

   // Channel history: two previous frames per channel, older one first.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            pow_old_ff[i]  <= '0;
            pow_new_ff[i]  <= '0;
            peak_old_ff[i] <= '0;
            peak_new_ff[i] <= '0;
            seen_ff[i]     <= '0;
         end
      end else if (cmd.vote && ch_ok) begin
         pow_old_ff[ch_idx]  <= pow_new_ff[ch_idx];
         pow_new_ff[ch_idx]  <= sum_ff;
         peak_old_ff[ch_idx] <= peak_new_ff[ch_idx];
         peak_new_ff[ch_idx] <= peak_bin_ff;
         if (seen_ff[ch_idx] != SEEN_MAX) begin
            seen_ff[ch_idx] <= seen_ff[ch_idx] + 1'b1;
         end
      end
   end

   always_comb begin
      if (appr_ff > dep_ff) begin
         verdict = VERDICT_APPROACH;
      end else if (appr_ff < dep_ff) begin
         verdict = VERDICT_DEPART;
      end else begin
         verdict = VERDICT_UNKNOWN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.emit) begin
         appr_ff <= '0;
         dep_ff  <= '0;
      end else if (cmd.vote) begin
         if ((vote == TREND_RISE) && (appr_ff != TALLY_MAX)) begin
            appr_ff <= appr_ff + 1'b1;
         end else if ((vote == TREND_FALL) && (dep_ff != TALLY_MAX)) begin
            dep_ff <= dep_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= {dep_ff, appr_ff, verdict};
      end
   end

   assign rsp_tdata = rsp_data_ff;

   assign status.counted      = counted;
   assign status.last_bin     = last_bin_ff;
   assign status.last_channel = last_ch_ff;
   assign status.root_busy    = root_busy;
   assign status.root_done    = root_done;

endmodule

### design/stmv_ctrl.sv
// Controller of the spectral trend motion voter: sequences one request at a
// time through the datapath and owns the response valid flag. Depends on stmv_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "spectral_trend_motion_vote_assert.svh"

module stmv_ctrl import stmv_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   input  stmv_status_type status,
   output stmv_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ROOT_LOAD,
      ST_ROOT_RUN,
      ST_ACCUM,
      ST_VOTE,
      ST_RESULT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      slot_free;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      cmd            = '0;
      cmd.load_item  = req_tvalid && req_tready;
      cmd.square     = (state_ff == ST_SQUARE);
      cmd.root_start = (state_ff == ST_ROOT_LOAD);
      cmd.accum      = (state_ff == ST_ACCUM);
      cmd.vote       = (state_ff == ST_VOTE);
      cmd.emit       = (state_ff == ST_RESULT) && slot_free;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (status.counted) begin
               state_in = ST_ROOT_LOAD;
            end else if (status.last_bin) begin
               state_in = ST_VOTE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_ROOT_LOAD: begin
            state_in = ST_ROOT_RUN;
         end
         ST_ROOT_RUN: begin
            if (status.root_done) begin
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            state_in = status.last_bin ? ST_VOTE : ST_IDLE;
         end
         ST_VOTE: begin
            state_in = status.last_channel ? ST_RESULT : ST_IDLE;
         end
         ST_RESULT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   // A request is only taken once the root unit has finished the previous one.
   `STMV_ASSERT_IMPL(a_accept_root_idle, clock, reset, req_tvalid && req_tready, !status.root_busy, "request accepted while root unit busy")
   // A result is never written over one that has not been taken.
   `STMV_ASSERT_IMPL(a_emit_slot_free, clock, reset, cmd.emit, !rsp_valid_ff || rsp_tready, "result overwritten before delivery")
   // The root unit only finishes while the controller waits for it.
   `STMV_ASSERT_IMPL(a_done_in_run, clock, reset, status.root_done, state_ff == ST_ROOT_RUN, "root completion outside wait state")

endmodule

### design/spectral_trend_motion_vote.sv
// Top level of the spectral trend motion voter: joins controller and datapath.
// Depends on stmv_pkg, stmv_ctrl and stmv_datapath.
`timescale 1ns / 1ps

// The block takes one complex FFT bin per request and works on one request
// at a time. A bin below start_bin needs only the square state before the next
// request can be taken; a counted bin also waits on the square root unit, which
// resolves one bit of the 24-bit magnitude per cycle. The bin that closes a
// channel's frame (tlast) adds the vote state, and the bin that also closes the
// frame set (last_channel) adds the result state, which waits for a free output
// slot. The result sits in an output register, so the next request is accepted
// while a result waits for rsp_tready; only a second result waits until the
// first is taken. Each frame sums floor(sqrt(re^2+im^2)) from start_bin on,
// saturating at 2^35-1, and keeps the first bin of greatest magnitude, or -1
// when no bin was counted. Each channel keeps its two previous frames; with at
// least two on record a closing frame votes approaching when the three sums
// rise strictly and departing when they fall strictly, else the three peak
// bins decide by the same rule. After the last channel one response carries
// the majority verdict and both vote counts, and the counts restart. start_bin
// resets to 3; the user must write it via csr_wr_en only while idle, unchecked.

module spectral_trend_motion_vote import stmv_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  csr_wr_en,
   input  logic [BIN_IDX_W-1:0]  csr_wr_data,   // start_bin

   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,     // bin_index, bin_real, bin_imag, zero pad
   input  logic [REQ_USER_W-1:0] req_tuser,     // channel, last_channel
   input  logic                  req_tlast,     // last_bin

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata      // verdict, approach_votes, depart_votes
);

   stmv_cmd_type    cmd;
   stmv_status_type status;

   // The controller steps each request through square and, where needed, root,
   // accumulate, vote and result, and holds the response valid flag.
   stmv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath holds the start_bin register, the running frame, the
   // per-channel history, the vote tallies and the response payload.
   stmv_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .cmd         (cmd),
      .status      (status),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

### bench/testbench.sv
// Self-checking bench for spectral_trend_motion_vote: streams FFT bin requests,
// predicts the per frame set vote and checks every response. Needs stmv_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
   import stmv_pkg::*;

   // Timing of the run. The quiet settle pause outlasts a counted bin, so it covers
   // any bin still in flight.
   localparam int SETTLE_CYCLES   = 40;
   localparam int HOLD_CYCLES     = 1500;
   localparam int WATCHDOG_LIMIT  = 8000;
   localparam int REPORT_LIMIT    = 10;
   localparam longint SUM_LIMIT   = (longint'(1) << SUM_W) - 1;
   localparam int TALLY_CAP       = 7;

   // One request as the bench sees it, before packing onto the stream ports.
   typedef struct {
      logic [CH_W-1:0]      channel;
      logic [BIN_IDX_W-1:0] bin;
      logic signed [23:0]   re;
      logic signed [23:0]   im;
      logic                 last_bin;
      logic                 last_channel;
   } fft_bin_type;

   // One response: the verdict of a frame set and both vote counts.
   typedef struct {
      verdict_type  verdict;
      logic [2:0]   approach_votes;
      logic [2:0]   depart_votes;
   } vote_result_type;

   // How a channel's frames drift from one frame set to the next. Rising or
   // falling amplitude drives the sum trend; shifting the frame drives the
   // peak trend while the sum stays put.
   typedef enum int {
      AMP_UP,
      AMP_DOWN,
      SHIFT_UP,
      SHIFT_DOWN,
      HOLD,
      RESHUFFLE
   } drift_kind_type;

   // Clock and reset. Reset is high from time zero and drops once.
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #1 clock = ~clock;

   // Block inputs, all known from the first cycle.
   logic                  csr_wr_en   = 1'b0;
   logic [BIN_IDX_W-1:0]  csr_wr_data = '0;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;   // bin_index, bin_real, bin_imag, zero pad
   logic [REQ_USER_W-1:0] req_tuser   = '0;   // channel, last_channel
   logic                  req_tlast   = 1'b0; // last_bin
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // verdict, approach_votes, depart_votes

   spectral_trend_motion_vote i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   // Requests waiting to be driven, the one on the bus now, and the responses
   // that the accepted requests are known to cause, oldest first.
   fft_bin_type     pending_bins[$];
   fft_bin_type     cur_bin;
   vote_result_type expected_verdicts[$];

   int  bins_queued   = 0;
   int  error_count   = 0;
   int  quiet_cycles  = 0;
   bit  req_taken     = 1'b0;
   bit  rsp_taken     = 1'b0;

   // Traffic shaping. calm turns off all random idling for the last part of
   // the run; hold_arm asks the receiver for one long hold-off.
   bit  calm          = 1'b0;
   bit  hold_arm      = 1'b0;
   bit  hold_done     = 1'b0;
   int  hold_left     = 0;
   int  send_gap      = 0;
   int  recv_gap      = 0;

   // Predicted state of the block: the running frame, two frames of history
   // per channel (older first), the frame count per channel and the tallies.
   int     cfg_start_bin    = 3;
   longint frame_sum        = 0;
   longint frame_peak_mag   = 0;
   bit     frame_peak_hit   = 1'b0;
   longint frame_peak_bin   = -1;
   longint sum_hist[CHANNELS*2];
   longint peak_hist[CHANNELS*2];
   int     frames_on_record[CHANNELS];
   int     approach_cnt     = 0;
   int     depart_cnt       = 0;

   // Stimulus memory per channel, so that successive frames form trends.
   int             ch_amp[4];
   int             ch_base[4];
   int             ch_count[4];
   int             ch_peak[4];
   drift_kind_type ch_drift[4];

   initial begin
      for (int i = 0; i < CHANNELS * 2; i++) begin
         sum_hist[i]  = 0;
         peak_hist[i] = 0;
      end
      for (int i = 0; i < CHANNELS; i++) begin
         frames_on_record[i] = 0;
      end
      for (int i = 0; i < 4; i++) begin
         ch_amp[i]   = $urandom_range(1, 5000);
         ch_base[i]  = $urandom_range(3, 30);
         ch_count[i] = $urandom_range(1, 4);
         ch_peak[i]  = $urandom_range(0, ch_count[i] - 1);
         ch_drift[i] = drift_kind_type'($urandom_range(0, 5));
      end
   end

   // Three values in a row: rising, falling or neither, both strict.
   function automatic trend_type trend_of(input longint a, input longint b, input longint c);
      if (a < b && b < c) begin
         return TREND_RISE;
      end
      if (a > b && b > c) begin
         return TREND_FALL;
      end
      return TREND_NONE;
   endfunction

   // Advances the predicted state by one accepted request and queues the
   // response that it causes, if any.
   task automatic predict_bin(input fft_bin_type b);
      longint re_abs;
      longint im_abs;
      longint power;
      longint mag;
      longint cand;
      int        ch;
      int        base;
      trend_type vote;
      vote_result_type res;
      re_abs = b.re;
      im_abs = b.im;
      if (re_abs < 0) begin
         re_abs = -re_abs;
      end
      if (im_abs < 0) begin
         im_abs = -im_abs;
      end
      if (b.bin >= cfg_start_bin && b.bin < FFT_SIZE) begin
         // Integer square root, built up one result bit at a time from the top.
         power = re_abs * re_abs + im_abs * im_abs;
         mag   = 0;
         for (int i = 24; i >= 0; i--) begin
            cand = mag | (longint'(1) << i);
            if (cand * cand <= power) begin
               mag = cand;
            end
         end
         frame_sum = (frame_sum + mag > SUM_LIMIT) ? SUM_LIMIT : frame_sum + mag;
         // A tie keeps the earlier bin as the peak.
         if (!frame_peak_hit || mag > frame_peak_mag) begin
            frame_peak_hit = 1'b1;
            frame_peak_mag = mag;
            frame_peak_bin = b.bin;
         end
      end
      if (b.last_bin) begin
         ch = b.channel;
         if (ch < CHANNELS) begin
            base = ch * 2;
            if (frames_on_record[ch] >= 2) begin
               vote = trend_of(sum_hist[base], sum_hist[base + 1], frame_sum);
               if (vote == TREND_NONE) begin
                  vote = trend_of(peak_hist[base], peak_hist[base + 1], frame_peak_bin);
               end
               if (vote == TREND_RISE && approach_cnt < TALLY_CAP) begin
                  approach_cnt++;
               end else if (vote == TREND_FALL && depart_cnt < TALLY_CAP) begin
                  depart_cnt++;
               end
            end
            sum_hist[base]      = sum_hist[base + 1];
            peak_hist[base]     = peak_hist[base + 1];
            sum_hist[base + 1]  = frame_sum;
            peak_hist[base + 1] = frame_peak_bin;
            if (frames_on_record[ch] < 3) begin
               frames_on_record[ch]++;
            end
         end
         frame_sum      = 0;
         frame_peak_mag = 0;
         frame_peak_hit = 1'b0;
         frame_peak_bin = -1;
         // The last channel only counts together with the last bin.
         if (b.last_channel) begin
            if (approach_cnt > depart_cnt) begin
               res.verdict = VERDICT_APPROACH;
            end else if (approach_cnt < depart_cnt) begin
               res.verdict = VERDICT_DEPART;
            end else begin
               res.verdict = VERDICT_UNKNOWN;
            end
            res.approach_votes = approach_cnt[2:0];
            res.depart_votes   = depart_cnt[2:0];
            expected_verdicts = {expected_verdicts, res};
            approach_cnt = 0;
            depart_cnt   = 0;
         end
      end
   endtask

   task automatic push_bin(input int ch, input int bin, input int re, input int im,
                           input bit lb, input bit lc);
      fft_bin_type b;
      b.channel      = CH_W'(ch);
      b.bin          = BIN_IDX_W'(bin);
      b.re           = 24'(re);
      b.im           = 24'(im);
      b.last_bin     = lb;
      b.last_channel = lc;
      pending_bins = {pending_bins, b};
      bins_queued++;
   endtask

   // One channel's frame: the peak bin carries amp and the others a quarter of
   // it. Only the sign and the part that carries the magnitude are random, so
   // the sum and the peak follow the channel's drift exactly.
   task automatic push_frame(input int ch, input int count, input int base,
                             input int peak_at, input int amp, input bit closes_set);
      int mag;
      for (int k = 0; k < count; k++) begin
         mag = (k == peak_at) ? amp : amp / 4;
         case ($urandom_range(0, 3))
            0: push_bin(ch, base + k, mag, 0, k == count - 1, closes_set);
            1: push_bin(ch, base + k, -mag, 0, k == count - 1, closes_set);
            2: push_bin(ch, base + k, 0, mag, k == count - 1, closes_set);
            default: push_bin(ch, base + k, 0, -mag, k == count - 1, closes_set);
         endcase
      end
   endtask

   // A frame set of all channels in order. A broken one takes channels at random,
   // repeats allowed, in any order, and may leave the set open.
   task automatic push_frame_set(input bit broken);
      int nch;
      int ch;
      int lo;
      int hi;
      bit closes;
      nch = broken ? $urandom_range(1, 4) : 4;
      for (int i = 0; i < nch; i++) begin
         ch = broken ? $urandom_range(0, 3) : i;
         if ($urandom_range(0, 3) == 0) begin
            ch_drift[ch] = drift_kind_type'($urandom_range(0, 5));
         end
         case (ch_drift[ch])
            AMP_UP: begin
               ch_amp[ch] += $urandom_range(1, ch_amp[ch] / 2 + 1);
               if (ch_amp[ch] >= 8388607) begin
                  ch_amp[ch]   = 8388607;
                  ch_drift[ch] = AMP_DOWN;
               end
            end
            AMP_DOWN: begin
               ch_amp[ch] -= $urandom_range(1, ch_amp[ch] / 2 + 1);
               if (ch_amp[ch] <= 1) begin
                  ch_amp[ch]   = 1;
                  ch_drift[ch] = AMP_UP;
               end
            end
            SHIFT_UP:   ch_base[ch]++;
            SHIFT_DOWN: ch_base[ch]--;
            RESHUFFLE: begin
               ch_count[ch] = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 12)
                                                          : $urandom_range(1, 4);
               ch_peak[ch]  = $urandom_range(0, ch_count[ch] - 1);
               ch_amp[ch]   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8388607)
                                                          : $urandom_range(1, 20000);
               lo = (cfg_start_bin > 3) ? cfg_start_bin - 3 : 0;
               hi = (cfg_start_bin < 1003) ? cfg_start_bin + 20 : 1023;
               ch_base[ch]  = $urandom_range(lo, hi);
            end
            default: ;
         endcase
         if (ch_base[ch] > 1024 - ch_count[ch]) begin
            ch_base[ch] = 1024 - ch_count[ch];
         end
         if (ch_base[ch] < 0) begin
            ch_base[ch] = 0;
         end
         closes = (i == nch - 1) && (!broken || $urandom_range(0, 1) == 1);
         push_frame(ch, ch_count[ch], ch_base[ch], ch_peak[ch], ch_amp[ch], closes);
      end
   endtask

   function automatic int rough_part();
      case ($urandom_range(0, 11))
         0: return -8388608;
         1: return 8388607;
         2: return 0;
         3: return -1;
         default: return int'($urandom() & 32'h00FF_FFFF);
      endcase
   endfunction

   // Mostly well-formed frame sets with drifting content, some broken ones,
   // and now and then a burst of entirely random requests.
   task automatic random_phase(input int n);
      int target;
      target = bins_queued + n;
      while (bins_queued < target) begin
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4)) begin
               push_bin($urandom_range(0, 3), $urandom_range(0, 1023), rough_part(),
                        rough_part(), $urandom_range(0, 2) == 0, $urandom_range(0, 1));
            end
         end else begin
            push_frame_set($urandom_range(0, 7) == 0);
         end
      end
   endtask

   // Waits until every request is out and every response is in, then lets a
   // bin that causes no response finish inside the block.
   task automatic drain();
      while (pending_bins.size() != 0 || req_tvalid || expected_verdicts.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_start_bin(input int value);
      @(negedge clock);
      csr_wr_en     <= 1'b1;
      csr_wr_data   <= BIN_IDX_W'(value);
      cfg_start_bin  = value;
      @(negedge clock);
      csr_wr_en     <= 1'b0;
   endtask

   // Request driver. A new request goes on the bus at the falling edge after
   // the previous one was accepted, unless a random gap starts first.
   always @(negedge clock) begin : drive_requests
      logic valid_next;
      if (!reset && (!req_tvalid || req_taken)) begin
         valid_next = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
         end else if (pending_bins.size() != 0) begin
            if (!calm && $urandom_range(0, 4) == 0) begin
               send_gap = $urandom_range(1, 9) - 1;
            end else begin
               cur_bin    = pending_bins[0];
               pending_bins.delete(0);
               valid_next = 1'b1;
               req_tdata  <= REQ_DATA_W'({cur_bin.im, cur_bin.re, cur_bin.bin});
               req_tuser  <= {cur_bin.last_channel, cur_bin.channel};
               req_tlast  <= cur_bin.last_bin;
            end
         end
         req_tvalid <= valid_next;
      end
   end

   // Response receiver. Once per run it holds off for a long stretch so that
   // the output register fills, a second response backs up and the block
   // stops taking requests. Otherwise, unless calm, it stalls in short random bursts.
   always @(negedge clock) begin : accept_responses
      logic ready_next;
      ready_next = 1'b1;
      if (hold_arm && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         ready_next = 1'b0;
      end else if (!calm) begin
         if (recv_gap > 0) begin
            recv_gap--;
            ready_next = 1'b0;
         end else if ($urandom_range(0, 5) == 0) begin
            recv_gap   = $urandom_range(1, 9) - 1;
            ready_next = 1'b0;
         end
      end
      rsp_tready <= ready_next;
   end

   // Monitor. Handshakes are sampled at the rising edge; a response is checked
   // against the oldest prediction, an accepted request advances the
   // predictor, and cycles with no handshake at all feed the watchdog.
   always @(posedge clock) begin : watch_ports
      vote_result_type exp_res;
      req_taken = req_tvalid && req_tready;
      rsp_taken = rsp_tvalid && rsp_tready;
      if (!reset) begin
         if (rsp_taken) begin
            if (expected_verdicts.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT) begin
                  $display("unexpected response at %0t: tdata %h", $realtime, rsp_tdata);
               end
            end else begin
               exp_res = expected_verdicts[0];
               expected_verdicts.delete(0);
               if (rsp_tdata[1:0] !== exp_res.verdict
                   || rsp_tdata[4:2] !== exp_res.approach_votes
                   || rsp_tdata[7:5] !== exp_res.depart_votes) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT) begin
                     $display({"response mismatch at %0t: verdict %0d/%0d approach %0d/%0d",
                               " depart %0d/%0d (expected/actual)"},
                              $realtime, exp_res.verdict, rsp_tdata[1:0],
                              exp_res.approach_votes, rsp_tdata[4:2],
                              exp_res.depart_votes, rsp_tdata[7:5]);
                  end
               end
            end
         end
         if (req_taken) begin
            predict_bin(cur_bin);
         end
         quiet_cycles = (req_taken || rsp_taken) ? 0 : quiet_cycles + 1;
      end
   end

   initial begin
      fork
         begin
            repeat (11) @(posedge clock);
            @(negedge clock);
            reset <= 1'b0;

            // Directed frame sets at the reset start_bin of 3, one bin per
            // frame mostly. Set one covers a peak tie, the full negative
            // corner, bin 1023, a bin just below start_bin and a last channel
            // flag without the last bin. By set three every channel votes:
            // channel 0 on rising sums, channel 1 on falling sums into an
            // empty frame, channel 2 on rising peaks with equal sums and
            // channel 3 on falling peaks ending at -1, a 2 to 2 tie.
            push_bin(0, 10, 1000, 0, 1'b0, 1'b0);
            push_bin(0, 11, 0, -1000, 1'b1, 1'b0);
            push_bin(1, 1023, -8388608, -8388608, 1'b1, 1'b0);
            push_bin(2, 20, 500, 0, 1'b1, 1'b0);
            push_bin(3, 2, 8388607, 8388607, 1'b0, 1'b1);
            push_bin(3, 50, 7, 0, 1'b1, 1'b1);

            push_bin(0, 10, 3000, 0, 1'b1, 1'b0);
            push_bin(1, 1023, 8388607, 8388607, 1'b1, 1'b0);
            push_bin(2, 21, 0, -500, 1'b1, 1'b0);
            push_bin(3, 40, 0, 7, 1'b1, 1'b1);

            push_bin(0, 12, -4000, 0, 1'b1, 1'b0);
            push_bin(1, 0, 8388607, -8388608, 1'b1, 1'b0);
            push_bin(2, 22, 500, 0, 1'b1, 1'b0);
            push_bin(3, 1, -1, 0, 1'b1, 1'b1);

            // Set four: only channels 0 and 2 see a trend, and channel 3
            // counts a zero bin exactly at start_bin.
            push_bin(0, 13, 5000, 0, 1'b1, 1'b0);
            push_bin(1, 500, 1, 0, 1'b1, 1'b0);
            push_bin(2, 23, 0, 500, 1'b1, 1'b0);
            push_bin(3, 3, 0, 0, 1'b1, 1'b1);
            drain();

            write_start_bin(0);
            random_phase(300);
            drain();

            write_start_bin(1023);
            random_phase(100);
            drain();

            // Every request closes a frame set, so responses pile up behind
            // the long hold-off.
            write_start_bin($urandom_range(0, 40));
            hold_arm = 1'b1;
            repeat (80) begin
               push_bin($urandom_range(0, 3), $urandom_range(0, 60), rough_part(),
                        rough_part(), 1'b1, 1'b1);
            end
            drain();

            repeat (3) begin
               write_start_bin(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                           : $urandom_range(0, 60));
               random_phase(230);
               drain();
            end

            // Last part without any idling on either side.
            write_start_bin(3);
            calm = 1'b1;
            random_phase(200);
            drain();
         end
         wait (quiet_cycles >= WATCHDOG_LIMIT);
      join_any

      if (quiet_cycles < WATCHDOG_LIMIT && error_count == 0
          && expected_verdicts.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+design
design/stmv_pkg.sv
design/stmv_isqrt.sv
design/stmv_datapath.sv
design/stmv_ctrl.sv
design/spectral_trend_motion_vote.sv
bench/testbench.sv
